[design/receive_char_reader_matcher_macros.svh]
// assertion macros for the receive character matcher
`ifndef RECEIVE_CHAR_READER_MATCHER_MACROS_SVH
`define RECEIVE_CHAR_READER_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF
`define RCRM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define RCRM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define RCRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RCRM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[design/rcrm_pkg.sv]
`default_nettype none

package rcrm_pkg;

    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR = 2'd0,
        OP_READ = 2'd1,
        OP_ECHO = 2'd2
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_READER   = 2'd0,
        KIND_ECHO     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] dest_id;
        logic [BYTE_W-1:0] out_char;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

`default_nettype wire

[design/rcrm_if.sv]
`default_nettype none

interface rcrm_req_if;
    logic                        valid;
    logic                        ready;
    logic [rcrm_pkg::OP_W-1:0]   opcode;
    logic [rcrm_pkg::BYTE_W-1:0] char_value;
    logic [rcrm_pkg::BYTE_W-1:0] requester_id;

    modport source (output valid, output opcode, output char_value, output requester_id,
                    input ready);
    modport sink (input valid, input opcode, input char_value, input requester_id,
                  output ready);
endinterface

interface rcrm_res_if;
    logic                        valid;
    logic                        ready;
    logic [rcrm_pkg::KIND_W-1:0] result_kind;
    logic [rcrm_pkg::BYTE_W-1:0] dest_id;
    logic [rcrm_pkg::BYTE_W-1:0] out_char;
    logic                        last;

    modport source (output valid, output result_kind, output dest_id, output out_char,
                    output last, input ready);
    modport sink (input valid, input result_kind, input dest_id, input out_char,
                  input last, output ready);
endinterface

`default_nettype wire

[design/receive_char_reader_matcher.sv]
// Pairs received characters with reader requests. Characters with no reader waiting are
// kept in a character FIFO and reader ids with no character buffered are kept in a reader
// FIFO, both held in single-port-read synchronous RAMs; a single echo requester may wait
// for a copy of the next arriving character while echo is enabled. Each request is taken
// in the idle state, the RAM heads are read on that edge, and the next cycle decides the
// outcome, updates the counters and writes any push back. Results then leave through an
// output register one per cycle unless the receiver applies back-pressure; the next request
// may be taken while the last result still waits in the output register. A push into a
// full FIFO drops the item and gives an overflow result. No RAM clearing is needed after
// reset.
`default_nettype none
`include "receive_char_reader_matcher_macros.svh"

module receive_char_reader_matcher #(
    parameter int CHAR_DEPTH   = 2048,
    parameter int READER_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rcrm_req_if.sink        i_req,
    rcrm_res_if.source      o_res,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata
);

    localparam int CAW = $clog2(CHAR_DEPTH);
    localparam int CCW = $clog2(CHAR_DEPTH + 1);
    localparam int RAW = $clog2(READER_DEPTH);
    localparam int RCW = $clog2(READER_DEPTH + 1);

    rcrm_pkg::t_state  r_state, n_state;
    rcrm_pkg::t_opcode r_op;
    logic [rcrm_pkg::BYTE_W-1:0] r_ch, r_id;

    logic [CAW-1:0] r_char_head, n_char_head;
    logic [CCW-1:0] r_char_cnt, n_char_cnt;
    logic [RAW-1:0] r_reader_head, n_reader_head;
    logic [RCW-1:0] r_reader_cnt, n_reader_cnt;
    logic           r_echo_wait, n_echo_wait;
    logic [rcrm_pkg::BYTE_W-1:0] r_echo_id, n_echo_id;
    logic           r_echo_en;

    rcrm_pkg::t_result r_pend0, r_pend1, n_pend0, n_pend1;
    logic [1:0]        r_pend_cnt, n_pend_cnt;
    logic              r_pend_idx;

    rcrm_pkg::t_result r_out;
    logic              r_out_valid;

    logic accept, load_ok, exec;
    logic char_we, reader_we;
    logic [rcrm_pkg::BYTE_W-1:0] char_rd, reader_rd;
    logic [CAW:0]   char_sum;
    logic [CAW-1:0] char_tail;
    logic [RAW:0]   reader_sum;
    logic [RAW-1:0] reader_tail;
    rcrm_pkg::t_result res_b;
    logic              res_b_valid, echo_hit;

    assign accept  = i_req.valid && i_req.ready;
    assign exec    = (r_state == rcrm_pkg::S_EXEC);
    assign load_ok = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == rcrm_pkg::S_IDLE);

    // tail positions with wrap for any depth
    always_comb begin
        char_sum = {1'b0, r_char_head} + (CAW+1)'(r_char_cnt);
        if (char_sum >= (CAW+1)'(CHAR_DEPTH)) begin
            char_sum = char_sum - (CAW+1)'(CHAR_DEPTH);
        end
        char_tail = char_sum[CAW-1:0];
        reader_sum = {1'b0, r_reader_head} + (RAW+1)'(r_reader_cnt);
        if (reader_sum >= (RAW+1)'(READER_DEPTH)) begin
            reader_sum = reader_sum - (RAW+1)'(READER_DEPTH);
        end
        reader_tail = reader_sum[RAW-1:0];
    end

    rcrm_ram #(.DEPTH(CHAR_DEPTH)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_tail),
        .i_wdata (r_ch),
        .i_re    (accept),
        .i_raddr (r_char_head),
        .o_rdata (char_rd)
    );

    rcrm_ram #(.DEPTH(READER_DEPTH)) u_reader_ram (
        .i_clk   (i_clk),
        .i_we    (reader_we),
        .i_waddr (reader_tail),
        .i_wdata (r_id),
        .i_re    (accept),
        .i_raddr (r_reader_head),
        .o_rdata (reader_rd)
    );

    always_comb begin
        n_char_head   = r_char_head;
        n_char_cnt    = r_char_cnt;
        n_reader_head = r_reader_head;
        n_reader_cnt  = r_reader_cnt;
        n_echo_wait   = r_echo_wait;
        n_echo_id     = r_echo_id;
        char_we       = 1'b0;
        reader_we     = 1'b0;
        echo_hit      = 1'b0;
        res_b         = '{rcrm_pkg::KIND_READER, '0, '0, 1'b1};
        res_b_valid   = 1'b0;
        case (r_op)
            rcrm_pkg::OP_CHAR: begin
                echo_hit = r_echo_en && r_echo_wait;
                if (echo_hit) begin
                    n_echo_wait = 1'b0;
                end
                if (r_reader_cnt != '0) begin
                    res_b       = '{rcrm_pkg::KIND_READER, reader_rd, r_ch, 1'b1};
                    res_b_valid = 1'b1;
                    n_reader_head = (r_reader_head == RAW'(READER_DEPTH - 1)) ?
                                    '0 : r_reader_head + 1'b1;
                    n_reader_cnt  = r_reader_cnt - 1'b1;
                end else if (r_char_cnt == CCW'(CHAR_DEPTH)) begin
                    res_b       = '{rcrm_pkg::KIND_OVERFLOW, '0, '0, 1'b1};
                    res_b_valid = 1'b1;
                end else begin
                    char_we    = exec;
                    n_char_cnt = r_char_cnt + 1'b1;
                end
            end
            rcrm_pkg::OP_READ: begin
                if (r_char_cnt != '0) begin
                    res_b       = '{rcrm_pkg::KIND_READER, r_id, char_rd, 1'b1};
                    res_b_valid = 1'b1;
                    n_char_head = (r_char_head == CAW'(CHAR_DEPTH - 1)) ?
                                  '0 : r_char_head + 1'b1;
                    n_char_cnt  = r_char_cnt - 1'b1;
                end else if (r_reader_cnt == RCW'(READER_DEPTH)) begin
                    res_b       = '{rcrm_pkg::KIND_OVERFLOW, r_id, '0, 1'b1};
                    res_b_valid = 1'b1;
                end else begin
                    reader_we    = exec;
                    n_reader_cnt = r_reader_cnt + 1'b1;
                end
            end
            rcrm_pkg::OP_ECHO: begin
                if (r_echo_en) begin
                    n_echo_wait = 1'b1;
                    n_echo_id   = r_id;
                end
            end
            default: begin
            end
        endcase

        // echo copy goes out ahead of the reader or overflow result
        if (echo_hit) begin
            n_pend0    = '{rcrm_pkg::KIND_ECHO, r_echo_id, r_ch, !res_b_valid};
            n_pend1    = res_b;
            n_pend_cnt = res_b_valid ? 2'd2 : 2'd1;
        end else begin
            n_pend0    = res_b;
            n_pend1    = res_b;
            n_pend_cnt = res_b_valid ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rcrm_pkg::S_EXEC;
                end
            end
            rcrm_pkg::S_EXEC: begin
                n_state = (n_pend_cnt != 2'd0) ? rcrm_pkg::S_DRAIN : rcrm_pkg::S_IDLE;
            end
            rcrm_pkg::S_DRAIN: begin
                if (load_ok && (r_pend_idx || r_pend_cnt == 2'd1)) begin
                    n_state = rcrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcrm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rcrm_pkg::S_IDLE;
            r_char_head   <= '0;
            r_char_cnt    <= '0;
            r_reader_head <= '0;
            r_reader_cnt  <= '0;
            r_echo_wait   <= 1'b0;
            r_echo_id     <= '0;
            r_echo_en     <= 1'b1;
            r_pend_cnt    <= 2'd0;
            r_pend_idx    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_echo_en <= i_cfg_wdata;
            end
            if (exec) begin
                r_char_head   <= n_char_head;
                r_char_cnt    <= n_char_cnt;
                r_reader_head <= n_reader_head;
                r_reader_cnt  <= n_reader_cnt;
                r_echo_wait   <= n_echo_wait;
                r_echo_id     <= n_echo_id;
                r_pend_cnt    <= n_pend_cnt;
                r_pend_idx    <= 1'b0;
            end
            if ((r_state == rcrm_pkg::S_DRAIN) && load_ok) begin
                r_out_valid <= 1'b1;
                r_pend_idx  <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= rcrm_pkg::t_opcode'(i_req.opcode);
            r_ch <= i_req.char_value;
            r_id <= i_req.requester_id;
        end
        if (exec) begin
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
        end
        if ((r_state == rcrm_pkg::S_DRAIN) && load_ok) begin
            r_out <= r_pend_idx ? r_pend1 : r_pend0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out.kind;
    assign o_res.dest_id     = r_out.dest_id;
    assign o_res.out_char    = r_out.out_char;
    assign o_res.last        = r_out.last;

    `RCRM_ASSERT_NEVER(a_char_cnt_bound, i_clk, i_rst_n, r_char_cnt > CCW'(CHAR_DEPTH), "character count beyond depth")
    `RCRM_ASSERT_NEVER(a_reader_cnt_bound, i_clk, i_rst_n, r_reader_cnt > RCW'(READER_DEPTH), "reader count beyond depth")
    `RCRM_ASSERT_NEVER(a_both_queued, i_clk, i_rst_n, (r_char_cnt != '0) && (r_reader_cnt != '0), "characters and readers queued together")
    `RCRM_ASSERT(a_accept_exec, i_clk, i_rst_n, accept |=> (r_state == rcrm_pkg::S_EXEC), "request not followed by execute")
    `RCRM_ASSERT_NEVER(a_drain_empty, i_clk, i_rst_n, (r_state == rcrm_pkg::S_DRAIN) && (r_pend_cnt == 2'd0), "drain with nothing pending")

endmodule

`default_nettype wire

[design/rcrm_ram.sv]
`default_nettype none

module rcrm_ram #(
    parameter int DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  wire logic [rcrm_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic      [rcrm_pkg::BYTE_W-1:0] o_rdata
);

    logic [rcrm_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [rcrm_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_DEPTH   = 2048;
    localparam int READER_DEPTH = 64;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 85;
    localparam logic [rcrm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [rcrm_pkg::OP_W-1:0]   op;
        logic [rcrm_pkg::BYTE_W-1:0] ch;
        logic [rcrm_pkg::BYTE_W-1:0] id;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    rcrm_req_if req_bus ();
    rcrm_res_if res_bus ();

    receive_char_reader_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [rcrm_pkg::BYTE_W-1:0] char_buf [CHAR_DEPTH];
    logic [10:0]                 char_head;
    logic [11:0]                 char_count;
    logic [rcrm_pkg::BYTE_W-1:0] reader_buf [READER_DEPTH];
    logic [5:0]                  reader_head;
    logic [6:0]                  reader_count;
    logic                        echo_pending;
    logic [rcrm_pkg::BYTE_W-1:0] echo_dest;
    logic                        echo_on;

    rcrm_pkg::t_result expected_results[$];
    t_request          request_fifo[$];

    int  reqs_issued;
    int  reqs_accepted;
    int  results_checked;
    int  errors;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_left;
    int  echo_results;
    int  overflow_results;
    bit  bus_loaded;

    task automatic predict_results(input t_request rq);
        rcrm_pkg::t_result pending[$];
        rcrm_pkg::t_result r;
        logic [10:0]       char_tail;
        logic [5:0]        reader_tail;
        case (rq.op)
            rcrm_pkg::OP_CHAR: begin
                if (echo_on && echo_pending) begin
                    r = '{kind: rcrm_pkg::KIND_ECHO, dest_id: echo_dest, out_char: rq.ch,
                          last: 1'b0};
                    pending.push_back(r);
                    echo_pending = 1'b0;
                end
                if (reader_count != 0) begin
                    r = '{kind: rcrm_pkg::KIND_READER, dest_id: reader_buf[reader_head],
                          out_char: rq.ch, last: 1'b0};
                    pending.push_back(r);
                    reader_head  = reader_head + 1'b1;
                    reader_count = reader_count - 1'b1;
                end else if (char_count == CHAR_DEPTH) begin
                    r = '{kind: rcrm_pkg::KIND_OVERFLOW, dest_id: '0, out_char: '0,
                          last: 1'b0};
                    pending.push_back(r);
                end else begin
                    char_tail           = char_head + char_count[10:0];
                    char_buf[char_tail] = rq.ch;
                    char_count          = char_count + 1'b1;
                end
            end
            rcrm_pkg::OP_READ: begin
                if (char_count != 0) begin
                    r = '{kind: rcrm_pkg::KIND_READER, dest_id: rq.id,
                          out_char: char_buf[char_head], last: 1'b0};
                    pending.push_back(r);
                    char_head  = char_head + 1'b1;
                    char_count = char_count - 1'b1;
                end else if (reader_count == READER_DEPTH) begin
                    r = '{kind: rcrm_pkg::KIND_OVERFLOW, dest_id: rq.id, out_char: '0,
                          last: 1'b0};
                    pending.push_back(r);
                end else begin
                    reader_tail             = reader_head + reader_count[5:0];
                    reader_buf[reader_tail] = rq.id;
                    reader_count            = reader_count + 1'b1;
                end
            end
            rcrm_pkg::OP_ECHO: begin
                if (echo_on) begin
                    echo_pending = 1'b1;
                    echo_dest    = rq.id;
                end
            end
            default: begin
            end
        endcase
        if (pending.size() > 0) begin
            pending[pending.size()-1].last = 1'b1;
        end
        foreach (pending[i]) begin
            expected_results.push_back(pending[i]);
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!bus_loaded && request_fifo.size() > 0 && i_rst_n
                && $urandom_range(0, 99) >= send_idle_pct) begin
            t_request rq;
            rq = request_fifo.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.opcode       <= rq.op;
            req_bus.char_value   <= rq.ch;
            req_bus.requester_id <= rq.id;
            bus_loaded = 1'b1;
        end else if (!bus_loaded) begin
            req_bus.valid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // request monitor
    always @(posedge i_clk) begin
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            predict_results('{op: req_bus.opcode, ch: req_bus.char_value,
                              id: req_bus.requester_id});
            reqs_accepted = reqs_accepted + 1;
            bus_loaded    = 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result: kind %0d dest %0d char %0d last %0d",
                         $time, res_bus.result_kind, res_bus.dest_id, res_bus.out_char,
                         res_bus.last);
            end else begin
                rcrm_pkg::t_result exp_r;
                exp_r = expected_results.pop_front();
                if (res_bus.result_kind !== exp_r.kind || res_bus.dest_id !== exp_r.dest_id
                        || res_bus.out_char !== exp_r.out_char
                        || res_bus.last !== exp_r.last) begin
                    errors = errors + 1;
                    $display("%0t: mismatch: expected kind %0d dest %0d char %0d last %0d, %s",
                             $time, exp_r.kind, exp_r.dest_id, exp_r.out_char, exp_r.last,
                             "actual below");
                    $display("%0t:           actual   kind %0d dest %0d char %0d last %0d",
                             $time, res_bus.result_kind, res_bus.dest_id, res_bus.out_char,
                             res_bus.last);
                end
                if (exp_r.kind == rcrm_pkg::KIND_ECHO) echo_results = echo_results + 1;
                if (exp_r.kind == rcrm_pkg::KIND_OVERFLOW) begin
                    overflow_results = overflow_results + 1;
                end
            end
            results_checked = results_checked + 1;
        end
    end

    // watchdog on stalled progress
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [rcrm_pkg::OP_W-1:0] op,
                                input logic [rcrm_pkg::BYTE_W-1:0] ch,
                                input logic [rcrm_pkg::BYTE_W-1:0] id);
        int num;
        reqs_issued = reqs_issued + 1;
        num         = reqs_issued;
        request_fifo.push_back('{op: op, ch: ch, id: id});
        while (reqs_accepted < num) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        while (expected_results.size() != 0 || reqs_accepted != reqs_issued) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_echo(input logic en);
        wait_quiet();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        echo_on = en;
    endtask

    task automatic test_reader_waits();
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h00);
        send_request(rcrm_pkg::OP_READ, 8'hff, 8'hff);
        send_request(rcrm_pkg::OP_CHAR, 8'h00, 8'hff);
        send_request(rcrm_pkg::OP_CHAR, 8'hff, 8'h00);
    endtask

    task automatic test_buffered_chars();
        send_request(rcrm_pkg::OP_CHAR, 8'h55, 8'h00);
        send_request(rcrm_pkg::OP_CHAR, 8'haa, 8'h00);
        send_request(rcrm_pkg::OP_READ, 8'hff, 8'h01);
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h02);
    endtask

    task automatic test_echo();
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'hff);
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h07);
        send_request(rcrm_pkg::OP_CHAR, 8'h3c, 8'h00);
        // a second echo request replaces the waiting one
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'h10);
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'h20);
        send_request(rcrm_pkg::OP_CHAR, 8'h81, 8'h00);
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h30);
    endtask

    task automatic test_echo_disabled();
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'h44);
        set_echo(1'b0);
        send_request(rcrm_pkg::OP_CHAR, 8'h5a, 8'h00);
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'h99);
        send_request(OP_UNUSED, 8'hff, 8'hff);
        set_echo(1'b1);
        send_request(rcrm_pkg::OP_CHAR, 8'ha5, 8'h00);
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h01);
        send_request(rcrm_pkg::OP_READ, 8'h00, 8'h02);
        wait_quiet();
    endtask

    task automatic test_reader_overflow();
        while (reader_count < READER_DEPTH) begin
            send_request(rcrm_pkg::OP_READ, 8'($urandom), 8'($urandom));
        end
        send_request(rcrm_pkg::OP_READ, 8'($urandom), 8'hc3);
        send_request(rcrm_pkg::OP_READ, 8'($urandom), 8'h3c);
        while (reader_count != 0) begin
            send_request(rcrm_pkg::OP_CHAR, 8'($urandom), 8'($urandom));
        end
        wait_quiet();
    endtask

    task automatic test_backpressure();
        int i;
        for (i = 0; i < 12; i++) send_request(rcrm_pkg::OP_READ, 8'h00, 8'(i));
        wait_quiet();
        hold_left = HOLD_CYCLES;
        send_request(rcrm_pkg::OP_ECHO, 8'h00, 8'hbe);
        for (i = 0; i < 16; i++) send_request(rcrm_pkg::OP_CHAR, 8'($urandom), 8'h00);
        for (i = 0; i < 4; i++) send_request(rcrm_pkg::OP_READ, 8'h00, 8'($urandom));
        wait_quiet();
    endtask

    task automatic test_random();
        int idle_set [4]  = '{0, 57, 0, 29};
        int stall_set [4] = '{0, 0, 57, 29};
        bit echo_set [4]  = '{1'b1, 1'b0, 1'b1, 1'b1};
        int phase;
        int counted;
        int pick;
        for (phase = 0; phase < 4; phase++) begin
            set_echo(echo_set[phase]);
            send_idle_pct  = idle_set[phase];
            recv_stall_pct = stall_set[phase];
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 44) begin
                    send_request(rcrm_pkg::OP_CHAR, 8'($urandom), 8'($urandom));
                    counted++;
                end else if (pick < 88) begin
                    send_request(rcrm_pkg::OP_READ, 8'($urandom), 8'($urandom));
                    counted++;
                end else if (pick < 96) begin
                    send_request(rcrm_pkg::OP_ECHO, 8'($urandom), 8'($urandom));
                    if (echo_on) counted++;
                end else begin
                    send_request(OP_UNUSED, 8'($urandom), 8'($urandom));
                end
            end
        end
        wait_quiet();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        req_bus.valid        = 1'b0;
        req_bus.opcode       = '0;
        req_bus.char_value   = '0;
        req_bus.requester_id = '0;
        res_bus.ready        = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        i_rst_n              = 1'b0;
        bus_loaded           = 1'b0;
        reqs_issued          = 0;
        reqs_accepted        = 0;
        results_checked      = 0;
        errors               = 0;
        idle_cycles          = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_left            = 0;
        echo_results         = 0;
        overflow_results     = 0;
        char_head            = '0;
        char_count           = '0;
        reader_head          = '0;
        reader_count         = '0;
        echo_pending         = 1'b0;
        echo_dest            = '0;
        echo_on              = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reader_waits();
        test_buffered_chars();
        test_echo();
        test_echo_disabled();
        test_reader_overflow();
        test_backpressure();
        test_random();
        set_echo(1'b1);

        wait_quiet();
        repeat (10) @(posedge i_clk);
        $display("covered: %0d requests, %0d results checked (%0d echo, %0d overflow)",
                 reqs_accepted, results_checked, echo_results, overflow_results);
        $display("covered: reader fifo filled to overflow, echo toggling, long receiver hold");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[receive_char_reader_matcher.f]
+incdir+design
design/rcrm_pkg.sv
design/rcrm_if.sv
design/rcrm_ram.sv
design/receive_char_reader_matcher.sv
bench/tb.sv
